// ----- hdl/ptts_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the periodic task tick scheduler.
// No dependencies; used by the top level and its checker.
package ptts_pkg;

   localparam int MS_W     = 16;
   localparam int TICK_W   = 13;
   localparam int SLOT_W   = 3;
   localparam int DUE_W    = 8;
   localparam int RSP_W    = 16;
   localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};

   localparam logic KIND_ADD  = 1'b0;
   localparam logic KIND_TICK = 1'b1;

   localparam logic STATUS_OK     = 1'b0;
   localparam logic STATUS_REJECT = 1'b1;

   typedef struct packed {
      logic [RSP_W-SLOT_W-DUE_W-2:0] pad;
      logic [DUE_W-1:0]              due_mask;
      logic [SLOT_W-1:0]             slot;
      logic                          status;
   } rsp_type;

endpackage

// ----- hdl/periodic_task_tick_scheduler.sv -----
`timescale 1ns / 1ps
// Periodic task tick scheduler: slot table with per-slot countdowns.
// An accepted req item enters the input register, then its result the result register.
// Throughput: one item per cycle; each item reads and updates the whole slot table
// in the combinational logic between the two registers. A stalled rsp item stalls the input.
// Reset (synchronous, active high) clears all slots to inactive and empties both registers;
// period and countdown storage is written by the add that claims a slot.
module periodic_task_tick_scheduler
   import ptts_pkg::*;
#(
   parameter int NUM_SLOTS = 8,
   parameter int TICK_MS   = 10
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [MS_W-1:0]  req_tdata,   // [15:0] period_ms
   input  logic [0:0]       req_tuser,   // [0] kind
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata    // [0] status, [3:1] slot, [11:4] due_mask, [15:12] 0
);

   localparam int DIV_N = MS_W + 1;
   localparam int DIV_L = $clog2(TICK_MS);
   localparam int DIV_S = DIV_N + DIV_L;
   localparam longint DIV_M_L = ((longint'(1) <<< DIV_S) + TICK_MS - 1) / TICK_MS;
   localparam logic [DIV_N:0] DIV_M = (DIV_N+1)'(DIV_M_L);
   localparam logic [DIV_N-1:0] ROUND_ADD = DIV_N'(TICK_MS - 1);
   localparam int PROD_W = 2 * DIV_N + 1;

   logic              in_valid_ff, in_valid_in;
   logic              in_kind_ff, in_kind_in;
   logic [MS_W-1:0]   in_ms_ff, in_ms_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic [NUM_SLOTS-1:0] active_ff, active_in;
   logic [TICK_W-1:0]    period_ff [NUM_SLOTS];
   logic [TICK_W-1:0]    period_in [NUM_SLOTS];
   logic [TICK_W-1:0]    remain_ff [NUM_SLOTS];
   logic [TICK_W-1:0]    remain_in [NUM_SLOTS];

   logic              advance;
   logic [DIV_N-1:0]  ms_sum;
   logic [PROD_W-1:0] prod;
   logic [DIV_N-1:0]  quot;
   logic [TICK_W-1:0] ticks;
   logic              free_found;
   logic [SLOT_W-1:0] free_slot;

   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff;

   assign ms_sum = DIV_N'(in_ms_ff) + ROUND_ADD;
   assign prod   = PROD_W'(ms_sum) * PROD_W'(DIV_M);
   assign quot   = DIV_N'(prod >> DIV_S);

   always_comb begin
      priority if (quot > DIV_N'(TICK_MAX)) begin
         ticks = TICK_MAX;
      end else if (quot == '0) begin
         ticks = TICK_W'(1);
      end else begin
         ticks = quot[TICK_W-1:0];
      end
   end

   always_comb begin
      free_found = 1'b0;
      free_slot  = '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         if (!active_ff[i] && !free_found) begin
            free_found = 1'b1;
            free_slot  = SLOT_W'(i);
         end
      end
   end

   always_comb begin
      logic claimed;
      claimed      = 1'b0;
      in_valid_in  = in_valid_ff;
      in_kind_in   = in_kind_ff;
      in_ms_in     = in_ms_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      active_in    = active_ff;
      period_in    = period_ff;
      remain_in    = remain_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (advance) begin
         in_valid_in  = 1'b0;
         rsp_valid_in = 1'b1;
         rsp_in       = '0;
         unique case (in_kind_ff)
            KIND_ADD: begin
               rsp_in.status = STATUS_REJECT;
               if (in_ms_ff != '0 && free_found) begin
                  rsp_in.status = STATUS_OK;
                  rsp_in.slot   = free_slot;
               end
               for (int i = 0; i < NUM_SLOTS; i++) begin
                  if (in_ms_ff != '0 && !active_ff[i] && !claimed) begin
                     claimed      = 1'b1;
                     active_in[i] = 1'b1;
                     period_in[i] = ticks;
                     remain_in[i] = ticks;
                  end
               end
            end
            KIND_TICK: begin
               for (int i = 0; i < NUM_SLOTS; i++) begin
                  if (active_ff[i]) begin
                     if (remain_ff[i] <= TICK_W'(1)) begin
                        remain_in[i] = period_ff[i];
                        if (i < DUE_W) begin
                           rsp_in.due_mask[i[$clog2(DUE_W)-1:0]] = 1'b1;
                        end
                     end else begin
                        remain_in[i] = remain_ff[i] - TICK_W'(1);
                     end
                  end
               end
            end
            default: begin
               rsp_in = '0;
            end
         endcase
      end
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
         in_kind_in  = req_tuser[0];
         in_ms_in    = req_tdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         active_ff    <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         active_ff    <= active_in;
      end
   end

   always_ff @(posedge clock) begin
      in_kind_ff <= in_kind_in;
      in_ms_ff   <= in_ms_in;
      rsp_ff     <= rsp_in;
      period_ff  <= period_in;
      remain_ff  <= remain_in;
   end

endmodule

// ----- hdl/ptts_checker.sv -----
`timescale 1ns / 1ps
// Port-level checker for the periodic task tick scheduler, with its bind.
// Depends on ptts_pkg; attaches to periodic_task_tick_scheduler.
module ptts_checker
   import ptts_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             req_tready,
   input logic             rsp_tvalid,
   input logic             rsp_tready,
   input logic [RSP_W-1:0] rsp_tdata
);

   rsp_type rsp;
   assign rsp = rsp_tdata;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp item changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid && req_tready)
      else $error("block not empty right after reset");

   a_reject_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp.status == STATUS_REJECT |-> rsp.slot == '0 && rsp.due_mask == '0)
      else $error("rejected add carries slot or due bits");

   a_due_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp.due_mask != '0 |-> rsp.status == STATUS_OK && rsp.slot == '0)
      else $error("tick item carries status or slot");

   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp.pad == '0)
      else $error("rsp padding bits not zero");

endmodule

bind periodic_task_tick_scheduler ptts_checker u_ptts_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ----- test/tb_periodic_task_tick_scheduler.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the periodic task tick scheduler: queued stimulus,
// in-line slot table prediction and field-by-field result checks.
// Depends on ptts_pkg and periodic_task_tick_scheduler.
module tb_periodic_task_tick_scheduler;
   import ptts_pkg::*;

   localparam int NUM_SLOTS    = 8;
   localparam int TICK_MS      = 10;
   localparam int RANDOM_ITEMS = 800;
   localparam int HOLD_AT      = 150;
   localparam int HOLD_CYCLES  = 400;
   localparam int PAUSE_AT     = 450;
   localparam int STALL_LIMIT  = 4000;
   localparam int MAX_REPORTS  = 10;

   typedef struct packed {
      logic            kind;
      logic [MS_W-1:0] period_ms;
   } sched_req_type;

   typedef struct {
      logic              status;
      logic [SLOT_W-1:0] slot;
      logic [DUE_W-1:0]  due_mask;
   } sched_result_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [MS_W-1:0]  req_tdata = '0;   // [15:0] period_ms
   logic [0:0]       req_tuser = '0;   // [0] kind
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;        // [0] status, [3:1] slot, [11:4] due_mask, [15:12] 0

   sched_req_type    pending_items[$];
   sched_result_type predicted_rsps[$];

   logic [TICK_W-1:0] period_tbl [NUM_SLOTS];
   logic [TICK_W-1:0] remain_tbl [NUM_SLOTS];
   logic [NUM_SLOTS-1:0] slot_used;

   int total_items;
   int offered;
   int phase = 0;
   bit pause_done;
   int rsp_accepts;
   int hold_left;
   bit hold_done;
   int mismatches = 0;
   int stall_cycles;

   periodic_task_tick_scheduler #(
      .NUM_SLOTS(NUM_SLOTS),
      .TICK_MS  (TICK_MS)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
   end

   task automatic predict_schedule(input logic kind, input logic [MS_W-1:0] ms);
      sched_result_type r;
      int unsigned ticks;
      r.status   = STATUS_OK;
      r.slot     = '0;
      r.due_mask = '0;
      if (kind == KIND_ADD) begin
         r.status = STATUS_REJECT;
         if (ms != 0) begin
            for (int s = 0; s < NUM_SLOTS; s++) begin
               if (!slot_used[s] && r.status == STATUS_REJECT) begin
                  ticks = (int'(ms) + TICK_MS - 1) / TICK_MS;
                  if (ticks == 0) ticks = 1;
                  if (ticks > TICK_MAX) ticks = TICK_MAX;
                  period_tbl[s] = ticks[TICK_W-1:0];
                  remain_tbl[s] = ticks[TICK_W-1:0];
                  slot_used[s]  = 1'b1;
                  r.status      = STATUS_OK;
                  r.slot        = s[SLOT_W-1:0];
               end
            end
         end
      end else begin
         for (int s = 0; s < NUM_SLOTS; s++) begin
            if (slot_used[s]) begin
               if (remain_tbl[s] != 0) remain_tbl[s] = remain_tbl[s] - 1'b1;
               if (remain_tbl[s] == 0) begin
                  remain_tbl[s] = period_tbl[s];
                  if (s < DUE_W) r.due_mask[s] = 1'b1;
               end
            end
         end
      end
      predicted_rsps.push_back(r);
   endtask

   // driver
   always @(posedge clock) begin
      int send_idle;
      sched_req_type item;
      if (reset) begin
         req_tvalid <= 1'b0;
         slot_used   = '0;
         offered     = 0;
         pause_done  = 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_schedule(req_tuser[0], req_tdata);
         end
         if (!(req_tvalid && !req_tready)) begin
            send_idle = (phase == 0) ? 20 : (phase == 1) ? 86 : 0;
            if (offered == PAUSE_AT && !pause_done && predicted_rsps.size() == 0) begin
               pause_done = 1'b1;
            end
            if (pending_items.size() > 0 && !(offered == PAUSE_AT && !pause_done) &&
                $urandom_range(99) >= send_idle) begin
               item = pending_items.pop_front();
               req_tdata  <= item.period_ms;
               req_tuser  <= item.kind;
               req_tvalid <= 1'b1;
               offered++;
               phase <= (offered < total_items / 3) ? 0 :
                        (offered < 2 * total_items / 3) ? 1 : 2;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      int recv_idle;
      rsp_type got;
      sched_result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_accepts = 0;
         hold_left   = 0;
         hold_done   = 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_type'(rsp_tdata);
            rsp_accepts++;
            if (predicted_rsps.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("unexpected rsp item: tdata=%h", rsp_tdata);
            end else begin
               want = predicted_rsps.pop_front();
               if (got.status !== want.status || got.slot !== want.slot ||
                   got.due_mask !== want.due_mask) begin
                  mismatches++;
                  if (mismatches <= MAX_REPORTS)
                     $display({"rsp %0d: expected status=%0d slot=%0d due=%h, ",
                               "got status=%0d slot=%0d due=%h"},
                              rsp_accepts, want.status, want.slot, want.due_mask,
                              got.status, got.slot, got.due_mask);
               end
            end
         end
         if (rsp_accepts == HOLD_AT && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            recv_idle = (phase == 0) ? 86 : (phase == 1) ? 20 : 0;
            rsp_tready <= ($urandom_range(99) >= recv_idle);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   task automatic queue_item(input logic kind, input logic [MS_W-1:0] ms);
      sched_req_type item;
      item.kind      = kind;
      item.period_ms = ms;
      pending_items.push_back(item);
   endtask

   initial begin
      logic kind;
      logic [MS_W-1:0] ms;
      // empty table, zero period, fill every slot, table full
      queue_item(KIND_TICK, 16'hFFFF);
      queue_item(KIND_ADD, 16'd0);
      queue_item(KIND_ADD, 16'd1);
      queue_item(KIND_ADD, 16'd9);
      queue_item(KIND_ADD, 16'd10);
      queue_item(KIND_ADD, 16'd11);
      queue_item(KIND_TICK, 16'h0000);
      queue_item(KIND_ADD, 16'd20);
      queue_item(KIND_ADD, 16'hFFFF);
      queue_item(KIND_TICK, 16'h5555);
      queue_item(KIND_ADD, 16'd25);
      queue_item(KIND_ADD, 16'd30);
      queue_item(KIND_ADD, 16'd40);
      queue_item(KIND_ADD, 16'd0);
      queue_item(KIND_ADD, 16'hFFFF);
      repeat (6) queue_item(KIND_TICK, 16'hAAAA);
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         kind = ($urandom_range(99) < 65) ? KIND_TICK : KIND_ADD;
         case ($urandom_range(3))
            0: ms = MS_W'($urandom_range(60));
            1: ms = $urandom_range(1) ? 16'hFFFF : 16'h0000;
            default: ms = MS_W'($urandom_range(16'hFFFF));
         endcase
         queue_item(kind, ms);
      end
      total_items = pending_items.size();

      while (pending_items.size() > 0 || req_tvalid || predicted_rsps.size() > 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
